>>> design/ptc_pkg.sv
// Shared widths, register codes, reset values and pipeline word types for the
// PID turn controller. No dependencies; every other design file imports it.
package ptc_pkg;

  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 7;
  localparam int GAIN_W     = 16;
  localparam int ZONE_W     = 15;
  localparam int DELAY_W    = 16;
  localparam int TICK_W     = 32;
  localparam int SUM_W      = 24;
  localparam int ERR_W      = ANGLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int LIM_W      = ANGLE_W + 2;
  localparam int DRIVE_W    = 8;
  localparam int FRAC_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int I_W   = GAIN_W + 1 + SUM_W;
  localparam int D_W   = GAIN_W + 1 + DIFF_W;
  localparam int TOT_W = I_W + 2;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [GAIN_W-1:0]  KP_RST     = GAIN_W'(1843);
  localparam logic [GAIN_W-1:0]  KI_RST     = GAIN_W'(20);
  localparam logic [GAIN_W-1:0]  KD_RST     = GAIN_W'(4096);
  localparam logic [ZONE_W-1:0]  IZONE_RST  = ZONE_W'(150);
  localparam logic [ZONE_W-1:0]  BAND_RST   = ZONE_W'(15);
  localparam logic [DELAY_W-1:0] EXIT_RST   = DELAY_W'(25);
  localparam logic [TICK_W-1:0]  EMERG_RST  = TICK_W'(250000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_IZONE = 3'd3,
    REG_BAND  = 3'd4,
    REG_EXIT  = 3'd5,
    REG_EMERG = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [ZONE_W-1:0]  izone;
    logic [ZONE_W-1:0]  band;
    logic [DELAY_W-1:0] exit_delay;
    logic [TICK_W-1:0]  emergency;
  } cfg_t;

  typedef struct packed {
    logic                     hold;
    logic                     done;
    logic                     zone;
    logic                     dir_neg;
    logic [SPEED_W-1:0]       speed;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  esum;
    logic signed [DIFF_W-1:0] diff;
  } calc_t;

  typedef struct packed {
    logic                   hold;
    logic                   done;
    logic                   zone;
    logic                   dir_neg;
    logic [SPEED_W-1:0]     speed;
    logic signed [P_W-1:0]  p_term;
    logic signed [I_W-1:0]  i_term;
    logic signed [D_W-1:0]  d_term;
  } prod_t;

  typedef struct packed {
    logic                    hold;
    logic                    done;
    logic                    zone;
    logic                    dir_neg;
    logic [SPEED_W-1:0]      speed;
    logic signed [TOT_W-1:0] total;
  } sum_t;

endpackage

>>> design/ptc_in_if.sv
// Command channel of the PID turn controller: start and tick words.
// Depends on ptc_pkg for the field widths.
interface ptc_in_if;
  import ptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [ANGLE_W-1:0] target_angle;
  logic [SPEED_W-1:0]        max_speed;
  logic signed [ANGLE_W-1:0] measured_angle;

  modport source (output valid, mode, target_angle, max_speed, measured_angle,
                  input ready);
  modport sink (input valid, mode, target_angle, max_speed, measured_angle,
                output ready);
endinterface

>>> design/ptc_out_if.sv
// Result channel of the PID turn controller: drive commands and status.
// Depends on ptc_pkg for the field widths.
interface ptc_out_if;
  import ptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_power;
  logic signed [DRIVE_W-1:0] right_power;
  logic                      in_zone;
  logic                      done_res;

  modport source (output valid, left_power, right_power, in_zone, done_res,
                  input ready);
  modport sink (input valid, left_power, right_power, in_zone, done_res,
                output ready);
endinterface

>>> design/ptc_cfg_if.sv
// Configuration write channel of the PID turn controller.
// Depends on ptc_pkg for the index and data widths.
interface ptc_cfg_if;
  import ptc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/ptc_cfg_regs.sv
// Configuration register file: gains, integral zone, settle band and timers.
// Depends on ptc_pkg and ptc_cfg_if.
module ptc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ptc_cfg_if.sink       cfg,
  output ptc_pkg::cfg_t regs
);
  import ptc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp         <= KP_RST;
      regs.ki         <= KI_RST;
      regs.kd         <= KD_RST;
      regs.izone      <= IZONE_RST;
      regs.band       <= BAND_RST;
      regs.exit_delay <= EXIT_RST;
      regs.emergency  <= EMERG_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_KP:    regs.kp         <= cfg.data[GAIN_W-1:0];
        REG_KI:    regs.ki         <= cfg.data[GAIN_W-1:0];
        REG_KD:    regs.kd         <= cfg.data[GAIN_W-1:0];
        REG_IZONE: regs.izone      <= cfg.data[ZONE_W-1:0];
        REG_BAND:  regs.band       <= cfg.data[ZONE_W-1:0];
        REG_EXIT:  regs.exit_delay <= cfg.data[DELAY_W-1:0];
        REG_EMERG: regs.emergency  <= cfg.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

>>> design/ptc_state_stage.sv
// Input register and controller state: error, integral accumulator, last error
// and settle tracking. Depends on ptc_pkg and ptc_in_if.
module ptc_state_stage (
  input  logic           clk,
  input  logic           rst,
  input  ptc_pkg::cfg_t  regs,
  ptc_in_if.sink         cmd,
  output logic           calc_valid,
  input  logic           calc_ready,
  output ptc_pkg::calc_t calc
);
  import ptc_pkg::*;

  logic                      s0_valid;
  logic                      s0_mode;
  logic signed [ANGLE_W-1:0] s0_target;
  logic [SPEED_W-1:0]        s0_speed;
  logic signed [ANGLE_W-1:0] s0_angle;

  logic signed [ANGLE_W-1:0] target_reg;
  logic [SPEED_W-1:0]        speed_limit;
  logic                      direction_neg;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic [TICK_W-1:0]         tick_count;
  logic [TICK_W-1:0]         check_start_tick;
  logic [TICK_W-1:0]         first_cross_tick;
  logic                      crossed_flag;
  logic                      settled_flag;

  logic                      s1_en;
  logic signed [ERR_W-1:0]   err;
  logic signed [LIM_W-1:0]   angle_x;
  logic signed [LIM_W-1:0]   zone_lim;
  logic signed [LIM_W-1:0]   lower;
  logic signed [LIM_W-1:0]   upper;
  logic                      zone;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SUM_W-1:0]   error_sum_next;
  logic signed [DIFF_W-1:0]  diff;
  logic [TICK_W-1:0]         tick_count_next;
  logic                      cross_now;
  logic [TICK_W-1:0]         check_eff;
  logic [TICK_W-1:0]         first_eff;
  logic                      check;
  logic                      in_band;
  logic                      emerg;
  logic                      settle_now;
  calc_t                     calc_next;

  assign s1_en     = !calc_valid || calc_ready;
  assign cmd.ready = !s0_valid || s1_en;

  assign err      = ERR_W'(target_reg) - ERR_W'(s0_angle);
  assign angle_x  = LIM_W'(s0_angle);
  assign zone_lim = $signed({{(LIM_W-ZONE_W){1'b0}}, regs.izone});
  assign lower    = LIM_W'(target_reg) - $signed({{(LIM_W-ZONE_W){1'b0}}, regs.band});
  assign upper    = LIM_W'(target_reg) + $signed({{(LIM_W-ZONE_W){1'b0}}, regs.band});
  assign zone     = LIM_W'(err) < zone_lim;

  assign sum_raw = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
  always_comb begin
    if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
      sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
  end
  assign error_sum_next = zone ? sum_sat : '0;
  assign diff           = DIFF_W'(err) - DIFF_W'(previous_error);

  assign tick_count_next = (&tick_count) ? tick_count : tick_count + 1'b1;
  assign cross_now  = !crossed_flag && (angle_x > lower);
  assign check_eff  = cross_now ? tick_count_next : check_start_tick;
  assign first_eff  = cross_now ? tick_count_next : first_cross_tick;
  assign check      = (crossed_flag || cross_now) &&
                      ({1'b0, tick_count_next} >
                       {1'b0, check_eff} + {{(TICK_W+1-DELAY_W){1'b0}}, regs.exit_delay});
  assign in_band    = (angle_x > lower) && (angle_x < upper);
  assign emerg      = {1'b0, tick_count_next} > {1'b0, first_eff} + {1'b0, regs.emergency};
  assign settle_now = check && (in_band || emerg);

  always_comb begin
    calc_next.hold    = 1'b1;
    calc_next.done    = 1'b0;
    calc_next.zone    = 1'b0;
    calc_next.dir_neg = direction_neg;
    calc_next.speed   = speed_limit;
    calc_next.err     = err;
    calc_next.esum    = error_sum_next;
    calc_next.diff    = diff;
    if (s0_mode == MODE_TICK) begin
      if (settled_flag) begin
        calc_next.done = 1'b1;
      end else begin
        calc_next.hold = settle_now;
        calc_next.done = settle_now;
        calc_next.zone = zone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid         <= 1'b0;
      calc_valid       <= 1'b0;
      target_reg       <= '0;
      speed_limit      <= '0;
      direction_neg    <= 1'b0;
      error_sum        <= '0;
      previous_error   <= '0;
      tick_count       <= '0;
      check_start_tick <= '0;
      first_cross_tick <= '0;
      crossed_flag     <= 1'b0;
      settled_flag     <= 1'b1;
    end else begin
      if (cmd.ready) begin
        s0_valid <= cmd.valid;
      end
      if (s1_en) begin
        calc_valid <= s0_valid;
      end
      if (s1_en && s0_valid) begin
        if (s0_mode == MODE_START) begin
          target_reg       <= s0_target;
          speed_limit      <= s0_speed;
          direction_neg    <= s0_target[ANGLE_W-1];
          error_sum        <= '0;
          previous_error   <= '0;
          tick_count       <= '0;
          check_start_tick <= '0;
          first_cross_tick <= '0;
          crossed_flag     <= 1'b0;
          settled_flag     <= 1'b0;
        end else if (!settled_flag) begin
          error_sum        <= error_sum_next;
          previous_error   <= err;
          tick_count       <= tick_count_next;
          first_cross_tick <= first_eff;
          crossed_flag     <= crossed_flag || cross_now;
          check_start_tick <= (check && !settle_now) ? tick_count_next : check_eff;
          settled_flag     <= settle_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s0_mode   <= cmd.mode;
      s0_target <= cmd.target_angle;
      s0_speed  <= cmd.max_speed;
      s0_angle  <= cmd.measured_angle;
    end
    if (s1_en && s0_valid) begin
      calc <= calc_next;
    end
  end
endmodule

>>> design/ptc_term_stage.sv
// Gain multiplication and term summation, two registered stages.
// Depends on ptc_pkg.
module ptc_term_stage (
  input  logic           clk,
  input  logic           rst,
  input  ptc_pkg::cfg_t  regs,
  input  logic           calc_valid,
  output logic           calc_ready,
  input  ptc_pkg::calc_t calc,
  output logic           sum_valid,
  input  logic           sum_ready,
  output ptc_pkg::sum_t  sum
);
  import ptc_pkg::*;

  logic  prod_valid;
  prod_t prod;
  logic  prod_en;
  logic  sum_en;

  assign sum_en     = !sum_valid || sum_ready;
  assign prod_en    = !prod_valid || sum_en;
  assign calc_ready = prod_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid <= calc_valid;
      end
      if (sum_en) begin
        sum_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en && calc_valid) begin
      prod.hold    <= calc.hold;
      prod.done    <= calc.done;
      prod.zone    <= calc.zone;
      prod.dir_neg <= calc.dir_neg;
      prod.speed   <= calc.speed;
      prod.p_term  <= $signed({1'b0, regs.kp}) * calc.err;
      prod.i_term  <= $signed({1'b0, regs.ki}) * calc.esum;
      prod.d_term  <= $signed({1'b0, regs.kd}) * calc.diff;
    end
    if (sum_en && prod_valid) begin
      sum.hold    <= prod.hold;
      sum.done    <= prod.done;
      sum.zone    <= prod.zone;
      sum.dir_neg <= prod.dir_neg;
      sum.speed   <= prod.speed;
      sum.total   <= TOT_W'(prod.p_term) + TOT_W'(prod.i_term) + TOT_W'(prod.d_term);
    end
  end
endmodule

>>> design/ptc_out_stage.sv
// Power scaling, clamping and the output register that drives the result
// channel. Depends on ptc_pkg and ptc_out_if.
module ptc_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          sum_valid,
  output logic          sum_ready,
  input  ptc_pkg::sum_t sum,
  ptc_out_if.source     res
);
  import ptc_pkg::*;

  localparam logic signed [TOT_W-1:0] POWER_MIN = -(TOT_W'(127));

  logic                      out_en;
  logic signed [TOT_W-1:0]   rounded;
  logic signed [TOT_W-1:0]   power;
  logic signed [TOT_W-1:0]   limit;
  logic signed [DRIVE_W-1:0] clamped;
  logic signed [DRIVE_W-1:0] drive;

  assign out_en    = !res.valid || res.ready;
  assign sum_ready = out_en;

  assign rounded = sum.total + $signed({{(TOT_W-FRAC_W){1'b0}}, {FRAC_W{sum.total[TOT_W-1]}}});
  assign power   = rounded >>> FRAC_W;
  assign limit   = $signed({{(TOT_W-SPEED_W){1'b0}}, sum.speed});

  always_comb begin
    if (power > limit) begin
      clamped = $signed({{(DRIVE_W-SPEED_W){1'b0}}, sum.speed});
    end else if (power < POWER_MIN) begin
      clamped = POWER_MIN[DRIVE_W-1:0];
    end else begin
      clamped = power[DRIVE_W-1:0];
    end
    if (sum.hold) begin
      drive = '0;
    end else if (sum.dir_neg) begin
      drive = -clamped;
    end else begin
      drive = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_en) begin
      res.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && sum_valid) begin
      res.left_power  <= drive;
      res.right_power <= -drive;
      res.in_zone     <= sum.zone;
      res.done_res    <= sum.done;
    end
  end
endmodule

>>> design/pid_turn_controller_core.sv
// PID heading controller for a differential drive with an integral zone.
// A command word passes the input register, the state update stage, the multiply
// stage, the summing stage and the output register. Throughput: one command word
// per cycle while the result channel is ready.
// Reset: gains and timers return to their defaults and the controller is idle,
// so tick words are answered with zero drive and done until a start word.
module pid_turn_controller_core (
  input  logic      clk,
  input  logic      rst,
  ptc_in_if.sink    cmd,
  ptc_out_if.source res,
  ptc_cfg_if.sink   cfg
);
  import ptc_pkg::*;

  cfg_t  regs;
  logic  calc_valid;
  logic  calc_ready;
  calc_t calc;
  logic  sum_valid;
  logic  sum_ready;
  sum_t  sum;

  ptc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ptc_state_stage u_state (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .cmd        (cmd),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc)
  );

  ptc_term_stage u_term (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  ptc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .res       (res)
  );

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res |-> res.left_power == '0)
    else $error("Settled result word carries a non-zero drive.");

  a_mirror: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.right_power == -res.left_power)
    else $error("Right drive is not the negation of left drive.");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.left_power != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("Drive command left the symmetric range.");

  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum.hold && sum_ready |=> res.valid && res.left_power == '0)
    else $error("Start or settled word produced a non-zero drive.");
endmodule
